// ===== sv/mrex_pkg.sv =====
// ----------------------------------------------------------------------------
// mrex_pkg
// Shared function codes, operation classes and item types of the R-type
// execute unit.
// ----------------------------------------------------------------------------
package mrex_pkg;

  // R-type function codes
  localparam logic [5:0] FN_SLL   = 6'h00;
  localparam logic [5:0] FN_SRL   = 6'h02;
  localparam logic [5:0] FN_SRA   = 6'h03;
  localparam logic [5:0] FN_JR    = 6'h08;
  localparam logic [5:0] FN_MFHI  = 6'h10;
  localparam logic [5:0] FN_MFLO  = 6'h12;
  localparam logic [5:0] FN_MULT  = 6'h18;
  localparam logic [5:0] FN_MULTU = 6'h19;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUB   = 6'h22;
  localparam logic [5:0] FN_AND   = 6'h24;
  localparam logic [5:0] FN_OR    = 6'h25;
  localparam logic [5:0] FN_XOR   = 6'h26;
  localparam logic [5:0] FN_NOR   = 6'h27;
  localparam logic [5:0] FN_NAND  = 6'h28;
  localparam logic [5:0] FN_SLT   = 6'h2a;

  // Decoupling queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ADD,
    OP_ADDU,
    OP_SUB,
    OP_AND,
    OP_OR,
    OP_XOR,
    OP_NOR,
    OP_NAND,
    OP_SLT,
    OP_SLL,
    OP_SRL,
    OP_SRA,
    OP_JR,
    OP_MULT,
    OP_MULTU,
    OP_MFHI,
    OP_MFLO
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_WR_ZERO   = 2'd1,
    ERR_OVERFLOW  = 2'd2,
    ERR_HILO_LOST = 2'd3
  } err_e;

  typedef struct packed {
    op_e         op;
    logic        writes;
    logic [31:0] rs_value;
    logic [31:0] rt_value;
    logic [4:0]  dest_index;
    logic [4:0]  shift_amount;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

// ===== sv/mrex_front.sv =====
// ----------------------------------------------------------------------------
// mrex_front
// Accepts requests and classifies the function code into an operation class.
// ----------------------------------------------------------------------------
module mrex_front (
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [5:0]           opcode_i,
  input  logic [31:0]          rs_value_i,
  input  logic [31:0]          rt_value_i,
  input  logic [4:0]           dest_index_i,
  input  logic [4:0]           shift_amount_i,
  input  mrex_pkg::q_status_t  q_status_i,
  output logic                 push_o,
  output mrex_pkg::item_t      push_item_o
);

  mrex_pkg::op_e op;

  always_comb begin
    unique case (opcode_i)
      mrex_pkg::FN_ADD:   op = mrex_pkg::OP_ADD;
      mrex_pkg::FN_ADDU:  op = mrex_pkg::OP_ADDU;
      mrex_pkg::FN_SUB:   op = mrex_pkg::OP_SUB;
      mrex_pkg::FN_AND:   op = mrex_pkg::OP_AND;
      mrex_pkg::FN_OR:    op = mrex_pkg::OP_OR;
      mrex_pkg::FN_XOR:   op = mrex_pkg::OP_XOR;
      mrex_pkg::FN_NOR:   op = mrex_pkg::OP_NOR;
      mrex_pkg::FN_NAND:  op = mrex_pkg::OP_NAND;
      mrex_pkg::FN_SLT:   op = mrex_pkg::OP_SLT;
      mrex_pkg::FN_SLL:   op = mrex_pkg::OP_SLL;
      mrex_pkg::FN_SRL:   op = mrex_pkg::OP_SRL;
      mrex_pkg::FN_SRA:   op = mrex_pkg::OP_SRA;
      mrex_pkg::FN_JR:    op = mrex_pkg::OP_JR;
      mrex_pkg::FN_MULT:  op = mrex_pkg::OP_MULT;
      mrex_pkg::FN_MULTU: op = mrex_pkg::OP_MULTU;
      mrex_pkg::FN_MFHI:  op = mrex_pkg::OP_MFHI;
      mrex_pkg::FN_MFLO:  op = mrex_pkg::OP_MFLO;
      default:            op = mrex_pkg::OP_NONE;
    endcase
  end

  assign in_stall_o = q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full;

  always_comb begin
    push_item_o.op           = op;
    // Jumps, multiplies and unknown codes make no register write.
    push_item_o.writes       = !(op == mrex_pkg::OP_NONE || op == mrex_pkg::OP_JR ||
                                 op == mrex_pkg::OP_MULT || op == mrex_pkg::OP_MULTU);
    push_item_o.rs_value     = rs_value_i;
    push_item_o.rt_value     = rt_value_i;
    push_item_o.dest_index   = dest_index_i;
    push_item_o.shift_amount = shift_amount_i;
  end

endmodule

// ===== sv/mrex_queue.sv =====
// ----------------------------------------------------------------------------
// mrex_queue
// Short FIFO of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module mrex_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  mrex_pkg::item_t      push_item_i,
  input  logic                 pop_i,
  output mrex_pkg::item_t      head_o,
  output mrex_pkg::q_status_t  status_o
);

  mrex_pkg::item_t                 mem_q [mrex_pkg::QDepth];
  logic [mrex_pkg::QPtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [mrex_pkg::QPtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [mrex_pkg::QCntW-1:0]      count_q, count_d;

  localparam logic [mrex_pkg::QPtrW-1:0] PtrLast = mrex_pkg::QPtrW'(mrex_pkg::QDepth - 1);
  localparam logic [mrex_pkg::QCntW-1:0] CntFull = mrex_pkg::QCntW'(mrex_pkg::QDepth);

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == CntFull);
  assign head_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== sv/mrex_back.sv =====
// ----------------------------------------------------------------------------
// mrex_back
// Executes the request at the head of the queue, keeps HI, LO and the unread
// flag, and holds the result in an output register.
// ----------------------------------------------------------------------------
module mrex_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mrex_pkg::item_t      head_i,
  input  mrex_pkg::q_status_t  q_status_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 write_enable_o,
  output logic [4:0]           write_index_o,
  output logic [31:0]          write_data_o,
  output logic                 jump_taken_o,
  output logic [31:0]          jump_target_o,
  output logic [1:0]           error_code_o
);

  logic        out_valid_q, out_valid_d;
  logic        we_q, we_d;
  logic [4:0]  widx_q, widx_d;
  logic [31:0] wdata_q, wdata_d;
  logic        jump_q, jump_d;
  logic [31:0] target_q, target_d;
  logic [1:0]  err_q, err_d;

  logic [31:0] hi_q, hi_d;
  logic [31:0] lo_q, lo_d;
  logic        pending_q, pending_d;

  logic [31:0] a, b, b_op, sum, data;
  logic        is_sub, is_signed_mul, ovf;
  logic [65:0] product;
  mrex_pkg::err_e err;

  assign a = head_i.rs_value;
  assign b = head_i.rt_value;

  // One adder serves add, addu and sub.
  assign is_sub = (head_i.op == mrex_pkg::OP_SUB);
  assign b_op   = is_sub ? ~b : b;
  assign sum    = a + b_op + {31'b0, is_sub};

  always_comb begin
    ovf = 1'b0;
    if (head_i.op == mrex_pkg::OP_ADD) begin
      ovf = (a[31] == b[31]) && (sum[31] != a[31]);
    end else if (is_sub) begin
      ovf = (a[31] != b[31]) && (sum[31] != a[31]);
    end
  end

  // Both multiplies use one 33 by 33 signed multiplier; HI and LO register it.
  assign is_signed_mul = (head_i.op == mrex_pkg::OP_MULT);
  assign product = $signed({is_signed_mul & a[31], a}) * $signed({is_signed_mul & b[31], b});

  always_comb begin
    unique case (head_i.op)
      mrex_pkg::OP_ADD,
      mrex_pkg::OP_ADDU,
      mrex_pkg::OP_SUB:  data = sum;
      mrex_pkg::OP_AND:  data = a & b;
      mrex_pkg::OP_OR:   data = a | b;
      mrex_pkg::OP_XOR:  data = a ^ b;
      mrex_pkg::OP_NOR:  data = ~(a | b);
      mrex_pkg::OP_NAND: data = ~(a & b);
      mrex_pkg::OP_SLT:  data = {31'b0, $signed(a) < $signed(b)};
      mrex_pkg::OP_SLL:  data = b << head_i.shift_amount;
      mrex_pkg::OP_SRL:  data = b >> head_i.shift_amount;
      mrex_pkg::OP_SRA:  data = $unsigned($signed(b) >>> head_i.shift_amount);
      mrex_pkg::OP_MFHI: data = hi_q;
      mrex_pkg::OP_MFLO: data = lo_q;
      default:           data = '0;
    endcase
  end

  assign pop_o = !q_status_i.empty && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    we_d        = we_q;
    widx_d      = widx_q;
    wdata_d     = wdata_q;
    jump_d      = jump_q;
    target_d    = target_q;
    err_d       = err_q;
    hi_d        = hi_q;
    lo_d        = lo_q;
    pending_d   = pending_q;
    err         = mrex_pkg::ERR_NONE;

    if (pop_o) begin
      if (head_i.op == mrex_pkg::OP_MULT || head_i.op == mrex_pkg::OP_MULTU) begin
        if (pending_q) begin
          err = mrex_pkg::ERR_HILO_LOST;
        end
        hi_d      = product[63:32];
        lo_d      = product[31:0];
        pending_d = 1'b1;
      end

      // A write to register zero is dropped and skips the overflow check.
      if (head_i.writes && head_i.dest_index == 5'd0) begin
        err = mrex_pkg::ERR_WR_ZERO;
      end else if (head_i.writes) begin
        if (ovf) begin
          err = mrex_pkg::ERR_OVERFLOW;
        end
        if (head_i.op == mrex_pkg::OP_MFHI || head_i.op == mrex_pkg::OP_MFLO) begin
          pending_d = 1'b0;
        end
      end

      out_valid_d = 1'b1;
      we_d        = head_i.writes && (head_i.dest_index != 5'd0);
      widx_d      = we_d ? head_i.dest_index : 5'd0;
      wdata_d     = we_d ? data : 32'd0;
      jump_d      = (head_i.op == mrex_pkg::OP_JR);
      target_d    = jump_d ? a : 32'd0;
      err_d       = err;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      hi_q        <= '0;
      lo_q        <= '0;
      pending_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      hi_q        <= hi_d;
      lo_q        <= lo_d;
      pending_q   <= pending_d;
    end
  end

  always_ff @(posedge clk_i) begin
    we_q     <= we_d;
    widx_q   <= widx_d;
    wdata_q  <= wdata_d;
    jump_q   <= jump_d;
    target_q <= target_d;
    err_q    <= err_d;
  end

  assign out_valid_o    = out_valid_q;
  assign write_enable_o = we_q;
  assign write_index_o  = widx_q;
  assign write_data_o   = wdata_q;
  assign jump_taken_o   = jump_q;
  assign jump_target_o  = target_q;
  assign error_code_o   = err_q;

endmodule

// ===== sv/mips_rtype_execute_unit.sv =====
// ----------------------------------------------------------------------------
// mips_rtype_execute_unit
// MIPS32 R-type execute unit with HI and LO registers.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                  Payload
//   in       input      in_valid_i / in_stall_o    opcode, rs, rt, dest, shamt
//   out      output     out_valid_o / out_stall_i  write, jump, error code
//
// One request a cycle is sustained while the output is not stalled; an
// accepted request is written into the queue, and the execute stage takes it
// from the queue head and loads its result into the output register. The
// execute stage holds the adder and the multiplier feeding HI and LO, so mfhi
// and mflo straight after a multiply see the new values.
// Reset clears HI, LO, the unread flag and all handshake state.
// A stalled output holds its result; the two-entry queue then fills and the
// input stalls.
// ----------------------------------------------------------------------------
module mips_rtype_execute_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [5:0]  opcode_i,
  input  logic [31:0] rs_value_i,
  input  logic [31:0] rt_value_i,
  input  logic [4:0]  dest_index_i,
  input  logic [4:0]  shift_amount_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        write_enable_o,
  output logic [4:0]  write_index_o,
  output logic [31:0] write_data_o,
  output logic        jump_taken_o,
  output logic [31:0] jump_target_o,
  output logic [1:0]  error_code_o
);

  mrex_pkg::q_status_t q_status;
  mrex_pkg::item_t     push_item;
  mrex_pkg::item_t     head;
  logic                push;
  logic                pop;

  mrex_front u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .rs_value_i     (rs_value_i),
    .rt_value_i     (rt_value_i),
    .dest_index_i   (dest_index_i),
    .shift_amount_i (shift_amount_i),
    .q_status_i     (q_status),
    .push_o         (push),
    .push_item_o    (push_item)
  );

  mrex_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  mrex_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .q_status_i     (q_status),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .write_enable_o (write_enable_o),
    .write_index_o  (write_index_o),
    .write_data_o   (write_data_o),
    .jump_taken_o   (jump_taken_o),
    .jump_target_o  (jump_target_o),
    .error_code_o   (error_code_o)
  );

endmodule

// ===== sv/mrex_checker.sv =====
// ----------------------------------------------------------------------------
// mrex_checker
// Port-level checks of the execute unit's results, bound to the top level.
// ----------------------------------------------------------------------------
module mrex_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        write_enable_o,
  input logic [4:0]  write_index_o,
  input logic [31:0] write_data_o,
  input logic        jump_taken_o,
  input logic [31:0] jump_target_o,
  input logic [1:0]  error_code_o
);

  // A stalled result stays on offer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // No write means zeroed write fields, and register zero is never written.
  a_write_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (write_enable_o ? (write_index_o != 5'd0)
                                    : (write_index_o == 5'd0 && write_data_o == 32'd0)))
    else $error("inconsistent write fields");

  // A jump makes no register write; without a jump the target is zero.
  a_jump_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (jump_taken_o ? !write_enable_o : (jump_target_o == 32'd0)))
    else $error("inconsistent jump fields");

  // Overflow keeps the write, a write to zero drops it, a lost HI/LO has none.
  a_error_vs_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((error_code_o != mrex_pkg::ERR_OVERFLOW || write_enable_o) &&
                     (error_code_o != mrex_pkg::ERR_WR_ZERO || !write_enable_o) &&
                     (error_code_o != mrex_pkg::ERR_HILO_LOST ||
                      (!write_enable_o && !jump_taken_o))))
    else $error("error code disagrees with write");

endmodule

bind mips_rtype_execute_unit mrex_checker u_mrex_checker (.*);

// ===== test/mips_rtype_execute_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_rtype_execute_unit_tb
// Self-checking bench for the R-type execute unit. A directed set of
// requests covers every function code, the edge values of the operands and
// the register-zero, overflow and HI/LO overwrite cases. Random requests
// follow, under random idling on both sides and one long output hold-off.
// Each request is run through a local model of the unit, and every result
// is compared with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module mips_rtype_execute_unit_tb;

  localparam logic [5:0] FN_UNUSED_LO = 6'h01;
  localparam logic [5:0] FN_UNUSED_HI = 6'h3f;
  localparam int unsigned RandomCount = 800;
  localparam int unsigned CalmTail    = 150;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned CycleLimit  = 200000;

  typedef struct {
    logic            write_enable;
    logic [4:0]      write_index;
    logic [31:0]     write_data;
    logic            jump_taken;
    logic [31:0]     jump_target;
    mrex_pkg::err_e  error_code;
  } rtype_result_t;

  class rtype_result_tracker;
    rtype_result_t expected_results[$];
    logic [31:0]   hi_q;
    logic [31:0]   lo_q;
    logic          hilo_unread;
    int unsigned   failures;

    function new();
      hi_q        = '0;
      lo_q        = '0;
      hilo_unread = 1'b0;
      failures    = 0;
    endfunction

    function rtype_result_t execute_rtype(logic [5:0] fn, logic [31:0] a, logic [31:0] b,
                                          logic [4:0] rd, logic [4:0] sh);
      rtype_result_t res;
      logic          writes;
      logic [31:0]   data;
      logic [63:0]   prod;
      writes = 1'b1;
      data   = '0;
      res.jump_taken  = 1'b0;
      res.jump_target = '0;
      res.error_code  = mrex_pkg::ERR_NONE;
      case (fn)
        mrex_pkg::FN_ADD, mrex_pkg::FN_ADDU: data = a + b;
        mrex_pkg::FN_SUB:   data = a - b;
        mrex_pkg::FN_AND:   data = a & b;
        mrex_pkg::FN_OR:    data = a | b;
        mrex_pkg::FN_XOR:   data = a ^ b;
        mrex_pkg::FN_NOR:   data = ~(a | b);
        mrex_pkg::FN_NAND:  data = ~(a & b);
        mrex_pkg::FN_SLT:   data = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
        mrex_pkg::FN_SLL:   data = b << sh;
        mrex_pkg::FN_SRL:   data = b >> sh;
        mrex_pkg::FN_SRA:   data = $signed(b) >>> sh;
        mrex_pkg::FN_MFHI:  data = hi_q;
        mrex_pkg::FN_MFLO:  data = lo_q;
        mrex_pkg::FN_JR: begin
          writes          = 1'b0;
          res.jump_taken  = 1'b1;
          res.jump_target = a;
        end
        mrex_pkg::FN_MULT, mrex_pkg::FN_MULTU: begin
          if (fn == mrex_pkg::FN_MULT) begin
            prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
          end else begin
            prod = {32'd0, a} * {32'd0, b};
          end
          if (hilo_unread) begin
            res.error_code = mrex_pkg::ERR_HILO_LOST;
          end
          hi_q        = prod[63:32];
          lo_q        = prod[31:0];
          hilo_unread = 1'b1;
          writes      = 1'b0;
        end
        default: writes = 1'b0;
      endcase

      // A write to register zero is dropped and takes precedence over overflow.
      if (writes && rd == 5'd0) begin
        writes         = 1'b0;
        res.error_code = mrex_pkg::ERR_WR_ZERO;
      end else if (writes) begin
        if (fn == mrex_pkg::FN_ADD && !(a[31] ^ b[31]) && (a[31] ^ data[31])) begin
          res.error_code = mrex_pkg::ERR_OVERFLOW;
        end
        if (fn == mrex_pkg::FN_SUB && (a[31] ^ b[31]) && (a[31] ^ data[31])) begin
          res.error_code = mrex_pkg::ERR_OVERFLOW;
        end
        if (fn == mrex_pkg::FN_MFHI || fn == mrex_pkg::FN_MFLO) begin
          hilo_unread = 1'b0;
        end
      end
      res.write_enable = writes;
      res.write_index  = writes ? rd : 5'd0;
      res.write_data   = writes ? data : 32'd0;
      return res;
    endfunction

    function void note_request(logic [5:0] fn, logic [31:0] a, logic [31:0] b,
                               logic [4:0] rd, logic [4:0] sh);
      expected_results.push_back(execute_rtype(fn, a, b, rd, sh));
    endfunction

    function void check_result(logic we, logic [4:0] widx, logic [31:0] wdata,
                               logic jt, logic [31:0] jtgt, logic [1:0] err);
      rtype_result_t exp;
      if (expected_results.size() == 0) begin
        $error("result arrived with no request outstanding");
        failures++;
        return;
      end
      exp = expected_results.pop_front();
      if (we !== exp.write_enable) begin
        $error("write_enable: expected %0b, got %0b", exp.write_enable, we);
        failures++;
      end
      if (widx !== exp.write_index) begin
        $error("write_index: expected %0d, got %0d", exp.write_index, widx);
        failures++;
      end
      if (wdata !== exp.write_data) begin
        $error("write_data: expected %h, got %h", exp.write_data, wdata);
        failures++;
      end
      if (jt !== exp.jump_taken) begin
        $error("jump_taken: expected %0b, got %0b", exp.jump_taken, jt);
        failures++;
      end
      if (jtgt !== exp.jump_target) begin
        $error("jump_target: expected %h, got %h", exp.jump_target, jtgt);
        failures++;
      end
      if (err !== exp.error_code) begin
        $error("error_code: expected %0d, got %0d", exp.error_code, err);
        failures++;
      end
    endfunction
  endclass

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [5:0]  opcode_i       = '0;
  logic [31:0] rs_value_i     = '0;
  logic [31:0] rt_value_i     = '0;
  logic [4:0]  dest_index_i   = '0;
  logic [4:0]  shift_amount_i = '0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic        write_enable_o;
  logic [4:0]  write_index_o;
  logic [31:0] write_data_o;
  logic        jump_taken_o;
  logic [31:0] jump_target_o;
  logic [1:0]  error_code_o;

  rtype_result_tracker tracker = new();
  bit          calm_tail    = 1'b0;
  bit          hold_off_req = 1'b0;
  int unsigned cycle_count  = 0;

  mips_rtype_execute_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .rs_value_i     (rs_value_i),
    .rt_value_i     (rt_value_i),
    .dest_index_i   (dest_index_i),
    .shift_amount_i (shift_amount_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .write_enable_o (write_enable_o),
    .write_index_o  (write_index_o),
    .write_data_o   (write_data_o),
    .jump_taken_o   (jump_taken_o),
    .jump_target_o  (jump_target_o),
    .error_code_o   (error_code_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Results are taken from the pre-edge values, as the unit sees them.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.check_result(write_enable_o, write_index_o, write_data_o,
                           jump_taken_o, jump_target_o, error_code_o);
    end
  end

  // The payload is held until the unit takes the request.
  task automatic send_request(logic [5:0] fn, logic [31:0] a, logic [31:0] b,
                              logic [4:0] rd, logic [4:0] sh);
    in_valid_i     <= 1'b1;
    opcode_i       <= fn;
    rs_value_i     <= a;
    rt_value_i     <= b;
    dest_index_i   <= rd;
    shift_amount_i <= sh;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_request(fn, a, b, rd, sh);
  endtask

  task automatic idle_input(int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  function automatic logic [5:0] pick_opcode();
    case ($urandom_range(0, 19))
      0:  return mrex_pkg::FN_SLL;
      1:  return mrex_pkg::FN_SRL;
      2:  return mrex_pkg::FN_SRA;
      3:  return mrex_pkg::FN_JR;
      4:  return mrex_pkg::FN_MFHI;
      5:  return mrex_pkg::FN_MFLO;
      6:  return mrex_pkg::FN_MULT;
      7:  return mrex_pkg::FN_MULTU;
      8:  return mrex_pkg::FN_ADD;
      9:  return mrex_pkg::FN_ADDU;
      10: return mrex_pkg::FN_SUB;
      11: return mrex_pkg::FN_AND;
      12: return mrex_pkg::FN_OR;
      13: return mrex_pkg::FN_XOR;
      14: return mrex_pkg::FN_NOR;
      15: return mrex_pkg::FN_NAND;
      16: return mrex_pkg::FN_SLT;
      default: return 6'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4: return 32'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned n;
    logic        level;
    wait (rst_ni);
    forever begin
      if (calm_tail) begin
        level = 1'b0;
        n     = 1;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        level        = 1'b1;
        n            = HoldCycles;
      end else if ($urandom_range(0, 2) == 0) begin
        level = 1'b1;
        n     = $urandom_range(1, 12);
      end else begin
        level = 1'b0;
        n     = $urandom_range(1, 30);
      end
      out_stall_i <= level;
      repeat (n) @(posedge clk_i);
    end
  end

  initial begin
    logic [5:0] fn;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(mrex_pkg::FN_ADD,   32'h7fff_ffff, 32'h0000_0001, 5'd1,  5'd0);
    send_request(mrex_pkg::FN_ADD,   32'h8000_0000, 32'hffff_ffff, 5'd31, 5'd0);
    send_request(mrex_pkg::FN_ADDU,  32'hffff_ffff, 32'hffff_ffff, 5'd2,  5'd31);
    send_request(mrex_pkg::FN_ADD,   32'h7fff_ffff, 32'h7fff_ffff, 5'd0,  5'd0);
    send_request(mrex_pkg::FN_SUB,   32'h8000_0000, 32'h0000_0001, 5'd3,  5'd0);
    send_request(mrex_pkg::FN_SUB,   32'h0000_0000, 32'h8000_0000, 5'd4,  5'd0);
    send_request(mrex_pkg::FN_AND,   32'hffff_ffff, 32'h5a5a_a5a5, 5'd5,  5'd0);
    send_request(mrex_pkg::FN_OR,    32'h0000_0000, 32'h8000_0001, 5'd6,  5'd0);
    send_request(mrex_pkg::FN_XOR,   32'hffff_ffff, 32'h0f0f_f0f0, 5'd7,  5'd0);
    send_request(mrex_pkg::FN_NOR,   32'h0000_0000, 32'h0000_0000, 5'd8,  5'd0);
    send_request(mrex_pkg::FN_NAND,  32'hffff_ffff, 32'hffff_ffff, 5'd9,  5'd0);
    send_request(mrex_pkg::FN_SLT,   32'h8000_0000, 32'h7fff_ffff, 5'd10, 5'd0);
    send_request(mrex_pkg::FN_SLT,   32'h7fff_ffff, 32'h8000_0000, 5'd11, 5'd0);
    send_request(mrex_pkg::FN_SLL,   32'h0000_0000, 32'hffff_ffff, 5'd12, 5'd31);
    send_request(mrex_pkg::FN_SRL,   32'h0000_0000, 32'h8000_0000, 5'd13, 5'd31);
    send_request(mrex_pkg::FN_SRA,   32'h0000_0000, 32'h8000_0000, 5'd14, 5'd31);
    send_request(mrex_pkg::FN_SRA,   32'h0000_0000, 32'h8000_0000, 5'd15, 5'd0);
    send_request(mrex_pkg::FN_JR,    32'hdead_beef, 32'h0000_0000, 5'd16, 5'd0);
    // Two multiplies in a row lose the first product; a read to register
    // zero leaves the unread flag set.
    send_request(mrex_pkg::FN_MULT,  32'h8000_0000, 32'hffff_ffff, 5'd0,  5'd0);
    send_request(mrex_pkg::FN_MULTU, 32'hffff_ffff, 32'hffff_ffff, 5'd0,  5'd0);
    send_request(mrex_pkg::FN_MFHI,  32'h0000_0000, 32'h0000_0000, 5'd0,  5'd0);
    send_request(mrex_pkg::FN_MFHI,  32'h0000_0000, 32'h0000_0000, 5'd17, 5'd0);
    send_request(mrex_pkg::FN_MFLO,  32'h0000_0000, 32'h0000_0000, 5'd18, 5'd0);
    send_request(FN_UNUSED_LO, 32'hffff_ffff, 32'hffff_ffff, 5'd31, 5'd31);
    send_request(FN_UNUSED_HI, 32'hffff_ffff, 32'hffff_ffff, 5'd31, 5'd31);

    for (int unsigned i = 0; i < RandomCount; i++) begin
      if (i == 100) begin
        hold_off_req = 1'b1;
      end
      if (i == RandomCount - CalmTail) begin
        calm_tail = 1'b1;
      end
      // A multiply is often followed by a read so that HI and LO get drained.
      if ((tracker.hilo_unread && $urandom_range(0, 2) == 0)) begin
        fn = ($urandom_range(0, 1) == 0) ? mrex_pkg::FN_MFHI : mrex_pkg::FN_MFLO;
      end else begin
        fn = pick_opcode();
      end
      send_request(fn, pick_operand(), pick_operand(),
                   ($urandom_range(0, 9) == 0) ? 5'd0 : 5'($urandom),
                   5'($urandom));
      if (!calm_tail && $urandom_range(0, 5) == 0) begin
        idle_input($urandom_range(1, 12));
      end
    end
    in_valid_i <= 1'b0;

    while (tracker.expected_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (tracker.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
